// ===== sv/trt_pkg.sv =====
// Shared types, constants and helpers for the TLS record sequence tracker.
package trt_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SEQ_W = 32;
    localparam int LEN_W = 16;
    localparam int REC_W = SEQ_W + LEN_W;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [1:0] {
        OP_APPEND      = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2,
        OP_LOOKUP      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [REC_W-1:0] wdata;
        logic [PTR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t              status;
        logic [SEQ_W-1:0]     found_start;
        logic [LEN_W-1:0]     found_length;
        logic [OUT_CNT_W-1:0] released_count;
        logic [OUT_CNT_W-1:0] occupancy;
    } result_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    // counts are reported modulo 128
    function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] wide;
        wide = {{OUT_CNT_W{1'b0}}, c};
        return wide[OUT_CNT_W-1:0];
    endfunction

    // wraparound compare: a is before b
    function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

endpackage

// ===== sv/trt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module trt_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/trt_ctrl.sv =====
// Ring pointers and the sequencer that walks the record RAM one entry per cycle.
module trt_ctrl
    import trt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  op_t              in_op,
    input  logic [SEQ_W-1:0] in_seq,
    input  logic [LEN_W-1:0] in_len,
    output ram_req_t         ram_req,
    input  logic [REC_W-1:0] ram_rdata,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] walk_ptr_reg, walk_ptr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] released_reg, released_next;
    op_t              op_reg, op_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    status_t          status_reg, status_next;
    logic [SEQ_W-1:0] fstart_reg, fstart_next;
    logic [LEN_W-1:0] flen_reg, flen_next;

    logic [SEQ_W-1:0] rec_start;
    logic [LEN_W-1:0] rec_len;
    logic [SEQ_W-1:0] rec_end;
    logic             hit;
    logic             last;

    assign rec_start = ram_rdata[SEQ_W-1:0];
    assign rec_len   = ram_rdata[REC_W-1:SEQ_W];
    assign rec_end   = rec_start + {{(SEQ_W-LEN_W){1'b0}}, rec_len};
    assign hit       = seq_before(seq_reg, rec_end);
    assign last      = (remain_reg == CNT_W'(1));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    assign res.status         = status_reg;
    assign res.found_start    = fstart_reg;
    assign res.found_length   = flen_reg;
    assign res.released_count = to_out_cnt(released_reg);
    assign res.occupancy      = to_out_cnt(count_reg);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        walk_ptr_next = walk_ptr_reg;
        remain_next   = remain_reg;
        released_next = released_reg;
        op_next       = op_reg;
        seq_next      = seq_reg;
        status_next   = status_reg;
        fstart_next   = fstart_reg;
        flen_next     = flen_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = tail_reg;
        ram_req.wdata = {in_len, in_seq};
        // idle reads the head so its entry is on the RAM output when a walk starts
        ram_req.raddr = (state_reg == S_WALK) ? ring_next(walk_ptr_reg) : head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next       = in_op;
                    seq_next      = in_seq;
                    released_next = '0;
                    status_next   = ST_OK;
                    fstart_next   = '0;
                    flen_next     = '0;
                    walk_ptr_next = head_reg;
                    remain_next   = count_reg;
                    state_next    = S_RESP;
                    unique case (in_op)
                        OP_APPEND: begin
                            if (count_reg >= CNT_W'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_req.we = 1'b1;
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_RELEASE_ALL: begin
                            head_next     = tail_reg;
                            count_next    = '0;
                            released_next = count_reg;
                        end
                        OP_RELEASE, OP_LOOKUP: begin
                            if (count_reg == '0) begin
                                if (in_op == OP_LOOKUP) begin
                                    status_next = ST_NOTFOUND;
                                end
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                walk_ptr_next = ring_next(walk_ptr_reg);
                remain_next   = remain_reg - CNT_W'(1);
                if (op_reg == OP_LOOKUP) begin
                    if (hit) begin
                        fstart_next = rec_start;
                        flen_next   = rec_len;
                        state_next  = S_RESP;
                    end else if (last) begin
                        status_next = ST_NOTFOUND;
                        state_next  = S_RESP;
                    end
                end else begin
                    if (hit) begin
                        state_next = S_RESP;
                    end else begin
                        head_next     = ring_next(head_reg);
                        count_next    = count_reg - CNT_W'(1);
                        released_next = released_reg + CNT_W'(1);
                        if (last) begin
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_ptr_reg <= walk_ptr_next;
        remain_reg   <= remain_next;
        released_reg <= released_next;
        op_reg       <= op_next;
        seq_reg      <= seq_next;
        status_reg   <= status_next;
        fstart_reg   <= fstart_next;
        flen_reg     <= flen_next;
    end

endmodule

// ===== sv/tls_record_seq_tracker_unit.sv =====
// Top level: record RAM, walk sequencer and registered result stream.
// Append and release-all deliver the result through S_RESP and the output register;
// release and lookup first walk the N ring entries examined (0..DEPTH) in S_WALK.
// One request at a time: a new request is taken only once the last result has left
// S_RESP, and the walk uses the single RAM read port one entry per cycle.
// Reset (aresetn low, synchronous) empties the ring and drops any pending result;
// RAM contents are not cleared and no sweep is needed.
module tls_record_seq_tracker_unit
    import trt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // seq[31:0], record_length[47:32]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // found_start[31:0], found_length[47:32],
                                   // released_count[54:48], occupancy[61:55], zero[63:62]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ram_req_t         ram_req;
    logic [REC_W-1:0] ram_rdata;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    logic             m_valid_reg, m_valid_next;
    logic [63:0]      m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;

    trt_ram #(
        .WIDTH (REC_W),
        .WORDS (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    trt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_seq    (s_tdata[31:0]),
        .in_len    (s_tdata[47:32]),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_user_next  = res.status;
            m_data_next  = {2'b00, res.occupancy, res.released_count,
                            res.found_length, res.found_start};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== sv/trt_checker.sv =====
// Port-level checks for the record tracker, bound to the top level.
module trt_checker
    import trt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a waiting request stays put until taken
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting request changed");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NOTFOUND) |-> (m_tdata[54:0] == '0))
        else $error("failed lookup carries record or release data");

    a_full_nothing_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[54:0] == '0))
        else $error("full append reports data");

endmodule

bind tls_record_seq_tracker_unit trt_checker u_trt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/tls_record_seq_tracker_unit_test.sv =====
// Self-checking testbench for the TLS record sequence tracker: directed table plus random traffic.
`timescale 1ns / 100ps

module tls_record_seq_tracker_unit_test;
    import trt_pkg::*;

    localparam int N_DIRECTED = 23;

    typedef struct {
        op_t         op;
        logic [31:0] seq;
        logic [15:0] len;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // seq[31:0], record_length[47:32]
    logic [1:0]  s_tuser = '0;    // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // found_start[31:0], found_length[47:32],
                                  // released_count[54:48], occupancy[61:55]
    logic [1:0]  m_tuser;         // status[1:0]

    // shadow copy of the record ring
    logic [31:0] ring_start [DEPTH];
    logic [15:0] ring_len [DEPTH];
    int          ring_head = 0;
    int          ring_tail = 0;
    int          ring_held = 0;

    result_t     due_results [$];
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] tx_next = '0;

    // typed rows: empty ring, extremes, full-range lengths; the rest are predicted
    stim_row_t dir_rows [N_DIRECTED] = '{
        '{OP_LOOKUP,      32'h0000_0000, 16'h0000, 1'b1, '{ST_NOTFOUND, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE_ALL, 32'h0000_0000, 16'h0000, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_APPEND,      32'hFFFF_FFF0, 16'hFFFF, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd1}},
        '{OP_APPEND,      32'h0000_FFEF, 16'h0000, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd2}},
        '{OP_APPEND,      32'h0000_FFEF, 16'h0001, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd3}},
        '{OP_LOOKUP,      32'hFFFF_FFF0, 16'hFFFF, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_LOOKUP,      32'h0000_FFEF, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_LOOKUP,      32'h0000_FFF0, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_LOOKUP,      32'h8000_0000, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE,     32'h0000_FFEE, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE,     32'h0000_FFEF, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_APPEND,      32'h0000_0000, 16'hFFFF, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_APPEND,      32'h7FFF_FFFF, 16'h8000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_LOOKUP,      32'hFFFF_FFFF, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE,     32'h7FFF_FFFF, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE_ALL, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE,     32'h0000_0000, 16'h0000, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_APPEND,      32'hAAAA_AAAA, 16'h5555, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd1}},
        '{OP_APPEND,      32'h5555_5555, 16'hAAAA, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd2}},
        '{OP_LOOKUP,      32'hAAAA_AAAA, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_LOOKUP,      32'h5555_5555, 16'h0000, 1'b0, '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0}},
        '{OP_RELEASE_ALL, 32'h1234_5678, 16'h0000, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd2, 7'd0}}
    };

    int send_idle_by_phase [4] = '{0, 75, 0, 9};
    int recv_stall_by_phase [4] = '{0, 0, 75, 9};

    tls_record_seq_tracker_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // a is before b in 32-bit wraparound order
    function automatic bit seq_precedes(input logic [31:0] a, input logic [31:0] b);
        return $signed(a - b) < 0;
    endfunction

    function automatic logic [31:0] record_end(input int idx);
        return ring_start[idx] + {16'h0, ring_len[idx]};
    endfunction

    // advances the shadow ring by one request and returns its response
    function automatic result_t track_records(input op_t op, input logic [31:0] seq,
                                              input logic [15:0] len);
        result_t r;
        int      released;
        int      p;
        bit      hit;
        r = '{ST_OK, 32'h0, 16'h0, 7'd0, 7'd0};
        released = 0;
        hit = 1'b0;
        case (op)
            OP_APPEND: begin
                if (ring_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_start[ring_tail] = seq;
                    ring_len[ring_tail] = len;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_held++;
                end
            end
            OP_RELEASE, OP_RELEASE_ALL: begin
                while (ring_held > 0) begin
                    if (op == OP_RELEASE && seq_precedes(seq, record_end(ring_head)))
                        break;
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_held--;
                    released++;
                end
            end
            default: begin
                p = ring_head;
                for (int i = 0; i < ring_held; i++) begin
                    if (seq_precedes(seq, record_end(p))) begin
                        r.found_start = ring_start[p];
                        r.found_length = ring_len[p];
                        hit = 1'b1;
                        break;
                    end
                    p = (p + 1) % DEPTH;
                end
                if (!hit)
                    r.status = ST_NOTFOUND;
            end
        endcase
        r.released_count = 7'(released);
        r.occupancy = 7'(ring_held);
        return r;
    endfunction

    // valid stays high across back-to-back requests; here it only drops for an idle gap
    task automatic drive_request(input op_t op, input logic [31:0] seq, input logic [15:0] len,
                                 input bit typed, input result_t want);
        result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {len, seq};
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = track_records(op, seq, len);
        due_results.push_back(typed ? want : predicted);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
    endtask

    // mostly contiguous appends with acks and queries aimed inside the held window
    task automatic run_traffic(input int n_items);
        int          done;
        int          pick;
        int          burst;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] q;
        logic [15:0] len;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            base = (ring_held > 0) ? ring_start[ring_head] : tx_next;
            span = tx_next - base;
            if (span < 32'h0100_0000)
                q = base - 32'd8 + 32'($urandom_range(0, span + 16));
            else
                q = $urandom;
            if (pick < 2 || done == 0) begin
                // overfill the ring to hit the full case
                burst = DEPTH - ring_held + $urandom_range(1, 4);
                repeat (burst) begin
                    len = 16'($urandom_range(0, 600));
                    drive_request(OP_APPEND, tx_next, len, 1'b0, '0);
                    tx_next += 32'(len);
                end
                done += burst;
            end else begin
                if (pick < 42) begin
                    len = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 1500))
                                                       : 16'($urandom_range(0, 65535));
                    if ($urandom_range(0, 9) == 0)
                        tx_next = $urandom;
                    drive_request(OP_APPEND, tx_next, len, 1'b0, '0);
                    tx_next += 32'(len);
                end else if (pick < 66) begin
                    drive_request(OP_LOOKUP, q, 16'($urandom), 1'b0, '0);
                end else if (pick < 88) begin
                    drive_request(OP_RELEASE, q, 16'($urandom), 1'b0, '0);
                end else if (pick < 91) begin
                    drive_request(OP_RELEASE_ALL, $urandom, 16'($urandom), 1'b0, '0);
                end else begin
                    drive_request(op_t'($urandom_range(0, 3)), $urandom,
                                  16'($urandom_range(0, 65535)), 1'b0, '0);
                end
                done++;
                if (pick == 99)
                    hold_until_drained();
            end
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir_rows[i])
            drive_request(dir_rows[i].op, dir_rows[i].seq, dir_rows[i].len,
                          dir_rows[i].typed, dir_rows[i].want);
        tx_next = 32'hFFFF_F000;  // cross the sequence wrap early
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_idle_by_phase[ph];
            recv_stall_pct <= recv_stall_by_phase[ph];
            run_traffic(282);
            hold_until_drained();
        end
        repeat (DEPTH + 8) @(posedge aclk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : response_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t ns: response with none expected, got tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("found_start", want.found_start, m_tdata[31:0]);
                check_field("found_length", 32'(want.found_length), 32'(m_tdata[47:32]));
                check_field("released_count", 32'(want.released_count), 32'(m_tdata[54:48]));
                check_field("occupancy", 32'(want.occupancy), 32'(m_tdata[61:55]));
            end
        end
    end

endmodule

// ===== filelist.f =====
sv/trt_pkg.sv
sv/trt_ram.sv
sv/trt_ctrl.sv
sv/tls_record_seq_tracker_unit.sv
sv/trt_checker.sv
verif/tls_record_seq_tracker_unit_test.sv
